// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/shbh_pkg.sv =====
// ----------------------------------------------------------------------------
// shbh_pkg
// Types, codes and default sizes of the string hash bucket histogram.
// ----------------------------------------------------------------------------
package shbh_pkg;

	// Default sizes
	localparam int DEF_TABLE_ENTRIES = 65536;
	localparam int DEF_MAX_WORD      = 256;
	localparam int DEF_COUNT_BITS    = 24;

	// Fixed field widths
	localparam int CHAR_BITS   = 8;
	localparam int HASH_BITS   = 16;
	localparam int SPREAD_BITS = 24;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_CHAR   = 2'd0,
		OP_END    = 2'd1,
		OP_REPORT = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_COUNTED  = 2'd0,
		ST_SPREAD   = 2'd1,
		ST_CLEARED  = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	// Hash selection
	typedef enum logic [1:0] {
		MODE_LEN    = 2'd0,
		MODE_FIRST  = 2'd1,
		MODE_SUM    = 2'd2,
		MODE_SUM_SQ = 2'd3
	} mode_t;

	// Shared unit operations
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// Word buffer control
	typedef struct packed {
		logic                 push;
		logic                 clear;
		logic [CHAR_BITS-1:0] ch;
	} word_ctl_t;

endpackage

// ===== hdl/shbh_alu.sv =====
// ----------------------------------------------------------------------------
// shbh_alu
// Shared add/subtract unit with borrow flag for compares.
// ----------------------------------------------------------------------------
module shbh_alu #(
	parameter int WIDTH = 24
) (
	input  shbh_pkg::alu_op_t op,
	input  logic [WIDTH-1:0]  a,
	input  logic [WIDTH-1:0]  b,
	output logic [WIDTH-1:0]  y,
	output logic              borrow
);
	import shbh_pkg::*;

	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] b_inv;
	logic             sub;

	// a + b, or a + ~b + 1 for subtract; carry out clear means a < b
	assign sub    = (op == ALU_SUB);
	assign b_inv  = sub ? ~b : b;
	assign sum    = {1'b0, a} + {1'b0, b_inv} + {{WIDTH{1'b0}}, sub};
	assign y      = sum[WIDTH-1:0];
	assign borrow = sub & ~sum[WIDTH];

endmodule

// ===== hdl/shbh_word.sv =====
// ----------------------------------------------------------------------------
// shbh_word
// Current word buffer: character memory, length, running sum, overflow flag.
// ----------------------------------------------------------------------------
module shbh_word #(
	parameter int MAX_WORD = 256,
	localparam int LEN_W = $clog2(MAX_WORD + 1),
	localparam int IDX_W = $clog2(MAX_WORD)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  shbh_pkg::word_ctl_t                ctl,
	input  logic [IDX_W-1:0]                   rd_addr,
	output logic [shbh_pkg::CHAR_BITS-1:0]     rd_data,
	output logic [LEN_W-1:0]                   len,
	output logic [shbh_pkg::HASH_BITS-1:0]     sum,
	output logic                               ovf
);
	import shbh_pkg::*;

	logic [CHAR_BITS-1:0] mem [MAX_WORD];
	logic [LEN_W-1:0]     len_q;
	logic [HASH_BITS-1:0] sum_q;
	logic                 ovf_q;
	logic                 full;

	assign full = (len_q == LEN_W'(MAX_WORD));

	// Character store, registered read
	always_ff @(posedge clk) begin
		if (ctl.push && !full) begin
			mem[len_q[IDX_W-1:0]] <= ctl.ch;
		end
		rd_data <= mem[rd_addr];
	end

	// Length, sum and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.clear) begin
			len_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.push) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				len_q <= len_q + LEN_W'(1);
				sum_q <= sum_q + HASH_BITS'(ctl.ch);
			end
		end
	end

	assign len = len_q;
	assign sum = sum_q;
	assign ovf = ovf_q;

endmodule

// ===== hdl/shbh_count_ram.sv =====
// ----------------------------------------------------------------------------
// shbh_count_ram
// Histogram counter memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module shbh_count_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 24,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/shbh_seq.sv =====
// ----------------------------------------------------------------------------
// shbh_seq
// Sequencer: hashing, bucket update and table scan over the shared unit, and clear.
// ----------------------------------------------------------------------------
module shbh_seq #(
	parameter int TABLE_ENTRIES = 65536,
	parameter int MAX_WORD      = 256,
	parameter int COUNT_BITS    = 24,
	parameter int ALU_W         = 24,
	localparam int ADDR_W = $clog2(TABLE_ENTRIES),
	localparam int LEN_W  = $clog2(MAX_WORD + 1),
	localparam int IDX_W  = $clog2(MAX_WORD)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  shbh_pkg::mode_t                    hash_mode,
	// Input items
	input  logic                               in_valid,
	output logic                               in_ready,
	input  shbh_pkg::op_t                      in_op,
	input  logic [shbh_pkg::CHAR_BITS-1:0]     in_char,
	// Result items
	output logic                               out_valid,
	input  logic                               out_ready,
	output shbh_pkg::status_t                  out_status,
	output logic [shbh_pkg::HASH_BITS-1:0]     out_bucket,
	output logic [shbh_pkg::SPREAD_BITS-1:0]   out_spread,
	// Word buffer
	output shbh_pkg::word_ctl_t                word_ctl,
	input  logic [LEN_W-1:0]                   word_len,
	input  logic [shbh_pkg::HASH_BITS-1:0]     word_sum,
	input  logic                               word_ovf,
	output logic [IDX_W-1:0]                   char_addr,
	input  logic [shbh_pkg::CHAR_BITS-1:0]     char_data,
	// Counter memory
	output logic                               ram_we,
	output logic [ADDR_W-1:0]                  ram_waddr,
	output logic [COUNT_BITS-1:0]              ram_wdata,
	output logic [ADDR_W-1:0]                  ram_raddr,
	input  logic [COUNT_BITS-1:0]              ram_rdata,
	// Shared unit
	output shbh_pkg::alu_op_t                  alu_op,
	output logic [ALU_W-1:0]                   alu_a,
	output logic [ALU_W-1:0]                   alu_b,
	input  logic [ALU_W-1:0]                   alu_y,
	input  logic                               alu_borrow
);
	import shbh_pkg::*;

	// Conditional subtract steps for the bucket reduction: quotient < 2^MOD_STEPS
	localparam int MOD_STEPS = 17 - $clog2(TABLE_ENTRIES);
	localparam int STEP_W    = $clog2(MOD_STEPS + 1);
	localparam logic [ADDR_W-1:0]     LAST_IDX  = ADDR_W'(TABLE_ENTRIES - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [10:0] {
		S_CLR     = 11'b000_0000_0001,
		S_IDLE    = 11'b000_0000_0010,
		S_RDC     = 11'b000_0000_0100,
		S_SUM     = 11'b000_0000_1000,
		S_MOD     = 11'b000_0001_0000,
		S_RDB     = 11'b000_0010_0000,
		S_INC     = 11'b000_0100_0000,
		S_CMP_MAX = 11'b000_1000_0000,
		S_CMP_MIN = 11'b001_0000_0000,
		S_SPREAD  = 11'b010_0000_0000,
		S_EMIT    = 11'b100_0000_0000
	} state_t;

	state_t                  state_q;
	logic [ADDR_W-1:0]       idx_q;
	logic [STEP_W-1:0]       step_q;
	logic [HASH_BITS-1:0]    h_q;
	logic [CHAR_BITS-1:0]    chr_q;
	logic [HASH_BITS-1:0]    sq_q;
	logic [COUNT_BITS-1:0]   cnt_q;
	logic [COUNT_BITS-1:0]   max_q;
	logic [COUNT_BITS-1:0]   min_q;
	logic                    seen_q;
	logic                    clr_op_q;
	status_t                 res_status_q;
	logic [HASH_BITS-1:0]    res_bucket_q;
	logic [SPREAD_BITS-1:0]  res_spread_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [HASH_BITS-1:0]    out_bucket_q;
	logic [SPREAD_BITS-1:0]  out_spread_q;

	logic                    accept;
	logic                    out_free;
	logic [CHAR_BITS-1:0]    char_eff;
	logic [HASH_BITS-1:0]    h_sel;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	// Empty word reads its first and middle character as zero
	assign char_eff  = (word_len == '0) ? '0 : char_data;
	assign char_addr = (hash_mode == MODE_FIRST) ? '0 : IDX_W'(word_len >> 1);

	// Word buffer control
	always_comb begin
		word_ctl.push  = accept && (in_op == OP_CHAR);
		word_ctl.clear = (accept && (in_op == OP_END) && word_ovf) || (state_q == S_INC);
		word_ctl.ch    = in_char;
	end

	// Hash selection
	always_comb begin
		case (hash_mode)
			MODE_LEN:    h_sel = HASH_BITS'(word_len);
			MODE_FIRST:  h_sel = HASH_BITS'(chr_q);
			MODE_SUM:    h_sel = word_sum;
			MODE_SUM_SQ: h_sel = alu_y[HASH_BITS-1:0];
			default:     h_sel = word_sum;
		endcase
	end

	// Shared unit operand selection
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_SUM: begin
				alu_a = ALU_W'(word_sum);
				alu_b = ALU_W'(sq_q);
			end
			S_MOD: begin
				alu_op = ALU_SUB;
				alu_a  = ALU_W'(h_q);
				alu_b  = ALU_W'(TABLE_ENTRIES) << step_q;
			end
			S_INC: begin
				alu_a = ALU_W'(ram_rdata);
				alu_b = ALU_W'(1);
			end
			S_CMP_MAX: begin
				alu_op = ALU_SUB;
				alu_a  = ALU_W'(max_q);
				alu_b  = ALU_W'(ram_rdata);
			end
			S_CMP_MIN: begin
				alu_op = ALU_SUB;
				alu_a  = ALU_W'(cnt_q);
				alu_b  = ALU_W'(min_q);
			end
			S_SPREAD: begin
				alu_op = ALU_SUB;
				alu_a  = ALU_W'(max_q);
				alu_b  = ALU_W'(min_q);
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	// Counter memory addressing; the scan fetches the next entry during the min compare
	always_comb begin
		case (state_q)
			S_IDLE:    ram_raddr = '0;
			S_CMP_MIN: ram_raddr = idx_q + ADDR_W'(1);
			S_RDB:     ram_raddr = h_q[ADDR_W-1:0];
			S_INC:     ram_raddr = h_q[ADDR_W-1:0];
			default:   ram_raddr = idx_q;
		endcase
	end

	assign ram_we    = (state_q == S_INC) || (state_q == S_CLR);
	assign ram_waddr = (state_q == S_INC) ? h_q[ADDR_W-1:0] : idx_q;
	assign ram_wdata = (state_q == S_CLR)         ? '0 :
	                   (ram_rdata == COUNT_MAX)   ? ram_rdata :
	                                                alu_y[COUNT_BITS-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			idx_q        <= '0;
			step_q       <= '0;
			clr_op_q     <= 1'b0;
			seen_q       <= 1'b0;
			h_q          <= '0;
			chr_q        <= '0;
			sq_q         <= '0;
			cnt_q        <= '0;
			max_q        <= '0;
			min_q        <= '0;
			res_status_q <= ST_COUNTED;
			res_bucket_q <= '0;
			res_spread_q <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_COUNTED;
			out_bucket_q <= '0;
			out_spread_q <= '0;
		end else begin
			// Output register: loaded from the emit state, dropped on transfer
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				// Clearing pass after reset and for the clear operation
				S_CLR: begin
					idx_q <= idx_q + ADDR_W'(1);
					if (idx_q == LAST_IDX) begin
						if (clr_op_q) begin
							res_status_q <= ST_CLEARED;
							res_bucket_q <= '0;
							res_spread_q <= '0;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (in_op)
							OP_END: begin
								if (word_ovf) begin
									res_status_q <= ST_TOO_LONG;
									res_bucket_q <= '0;
									res_spread_q <= '0;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_RDC;
								end
							end
							OP_REPORT: begin
								idx_q   <= '0;
								max_q   <= '0;
								min_q   <= '0;
								seen_q  <= 1'b0;
								state_q <= S_CMP_MAX;
							end
							OP_CLEAR: begin
								idx_q    <= '0;
								clr_op_q <= 1'b1;
								state_q  <= S_CLR;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				// Character read back; square it for the sum-plus-square hash
				S_RDC: begin
					chr_q   <= char_eff;
					sq_q    <= HASH_BITS'(char_eff) * HASH_BITS'(char_eff);
					state_q <= S_SUM;
				end
				S_SUM: begin
					h_q     <= h_sel;
					step_q  <= STEP_W'(MOD_STEPS - 1);
					state_q <= S_MOD;
				end
				// Bucket reduction by conditional subtracts of shifted table size
				S_MOD: begin
					if (!alu_borrow) begin
						h_q <= alu_y[HASH_BITS-1:0];
					end
					if (step_q == '0) begin
						state_q <= S_RDB;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				S_RDB: begin
					state_q <= S_INC;
				end
				// Saturating increment written back this cycle
				S_INC: begin
					res_status_q <= ST_COUNTED;
					res_bucket_q <= h_q;
					res_spread_q <= '0;
					state_q      <= S_EMIT;
				end
				S_CMP_MAX: begin
					cnt_q <= ram_rdata;
					if (alu_borrow) begin
						max_q <= ram_rdata;
					end
					state_q <= S_CMP_MIN;
				end
				S_CMP_MIN: begin
					if ((cnt_q != '0) && (!seen_q || alu_borrow)) begin
						min_q  <= cnt_q;
						seen_q <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= S_SPREAD;
					end else begin
						idx_q   <= idx_q + ADDR_W'(1);
						state_q <= S_CMP_MAX;
					end
				end
				S_SPREAD: begin
					res_status_q <= ST_SPREAD;
					res_bucket_q <= '0;
					res_spread_q <= alu_y[SPREAD_BITS-1:0];
					state_q      <= S_EMIT;
				end
				// Hand the result to the output register once it is free
				S_EMIT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_bucket_q <= res_bucket_q;
						out_spread_q <= res_spread_q;
						clr_op_q     <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_bucket = out_bucket_q;
	assign out_spread = out_spread_q;

endmodule

// ===== hdl/string_hash_bucket_histogram.sv =====
// ----------------------------------------------------------------------------
// string_hash_bucket_histogram
// Hashes streamed words into buckets and keeps a saturating histogram.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the block is idle. After reset the
// block runs a clearing pass over every counter entry before s_axis_tready
// rises. An end of word passes from transfer to result through char read,
// square, sum, bucket reduction steps on the shared add/subtract unit, counter
// read and write back; a too-long word goes straight to the result. A report
// walks the counter memory through its single read port, a max compare and a
// min compare per entry; a clear writes one entry per cycle. The input is not
// ready while an item is in work; results wait in an output register.
module string_hash_bucket_histogram #(
	parameter int TABLE_ENTRIES = shbh_pkg::DEF_TABLE_ENTRIES,
	parameter int MAX_WORD      = shbh_pkg::DEF_MAX_WORD,
	parameter int COUNT_BITS    = shbh_pkg::DEF_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [15:0] bucket, [39:16] spread
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	// Configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data        // [1:0] hash_mode
);
	import shbh_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_ENTRIES);
	localparam int LEN_W  = $clog2(MAX_WORD + 1);
	localparam int IDX_W  = $clog2(MAX_WORD);
	localparam int ALU_W  = (COUNT_BITS > SPREAD_BITS) ? COUNT_BITS : SPREAD_BITS;

	mode_t                  hash_mode_q;
	word_ctl_t              word_ctl;
	logic [LEN_W-1:0]       word_len;
	logic [HASH_BITS-1:0]   word_sum;
	logic                   word_ovf;
	logic [IDX_W-1:0]       char_addr;
	logic [CHAR_BITS-1:0]   char_data;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [COUNT_BITS-1:0]  ram_wdata;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [COUNT_BITS-1:0]  ram_rdata;
	alu_op_t                alu_op;
	logic [ALU_W-1:0]       alu_a;
	logic [ALU_W-1:0]       alu_b;
	logic [ALU_W-1:0]       alu_y;
	logic                   alu_borrow;
	status_t                out_status;
	logic [HASH_BITS-1:0]   out_bucket;
	logic [SPREAD_BITS-1:0] out_spread;

	// Hash mode register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q <= MODE_LEN;
		end else if (cfg_valid) begin
			hash_mode_q <= mode_t'(cfg_data);
		end
	end

	shbh_word #(
		.MAX_WORD (MAX_WORD)
	) u_word (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (word_ctl),
		.rd_addr (char_addr),
		.rd_data (char_data),
		.len     (word_len),
		.sum     (word_sum),
		.ovf     (word_ovf)
	);

	shbh_count_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH (COUNT_BITS)
	) u_count_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	shbh_alu #(
		.WIDTH (ALU_W)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.y      (alu_y),
		.borrow (alu_borrow)
	);

	shbh_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_WORD      (MAX_WORD),
		.COUNT_BITS    (COUNT_BITS),
		.ALU_W         (ALU_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.hash_mode  (hash_mode_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (op_t'(s_axis_tuser)),
		.in_char    (s_axis_tdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (out_status),
		.out_bucket (out_bucket),
		.out_spread (out_spread),
		.word_ctl   (word_ctl),
		.word_len   (word_len),
		.word_sum   (word_sum),
		.word_ovf   (word_ovf),
		.char_addr  (char_addr),
		.char_data  (char_data),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.alu_op     (alu_op),
		.alu_a      (alu_a),
		.alu_b      (alu_b),
		.alu_y      (alu_y),
		.alu_borrow (alu_borrow)
	);

	// Result packing
	assign m_axis_tdata = {out_spread, out_bucket};
	assign m_axis_tuser = out_status;

endmodule

// ===== hdl/shbh_checker.sv =====
// ----------------------------------------------------------------------------
// shbh_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shbh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import shbh_pkg::*;

	// A stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// Only a counted word carries a bucket
	`ASSERT_SAME(a_bucket_zero, clk, arst_n, m_axis_tvalid && (m_axis_tuser != ST_COUNTED), m_axis_tdata[15:0] == 16'd0, "bucket set on non-count result")

	// Only a report carries a spread
	`ASSERT_SAME(a_spread_zero, clk, arst_n, m_axis_tvalid && (m_axis_tuser != ST_SPREAD), m_axis_tdata[39:16] == 24'd0, "spread set on non-report result")

	// Any transfer other than a character makes the block busy
	`ASSERT_NEXT(a_busy_after_op, clk, arst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_CHAR), !s_axis_tready, "input ready right after a table operation")

endmodule

bind string_hash_bucket_histogram shbh_checker u_shbh_checker (.*);

// ===== verif/string_hash_bucket_histogram_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_hash_bucket_histogram_tb
// Drives words, reports and clears into the histogram block under all four hash
// modes; checks every result against a bucket and spread predictor or a fixed row.
// ----------------------------------------------------------------------------
// A directed table covers the empty table, empty words, the longest word, a
// rejected word and partial words across report and clear. Random phases
// follow, mostly well-formed words with random content, each under its own
// hash mode. Both stream sides idle at random, except for one burst phase. The
// result side also holds off once so that the block backs up into its input.
module string_hash_bucket_histogram_tb;

	import shbh_pkg::*;

	localparam int TBL_ENTRIES  = DEF_TABLE_ENTRIES;
	localparam int WORD_MAX     = DEF_MAX_WORD;
	localparam int CNT_BITS     = DEF_COUNT_BITS;
	// Settling time before a register write and at the end
	localparam int DRAIN_CYCLES = 16;
	// A report walks the whole table, a max and a min compare per entry
	localparam int QUIET_LIMIT  = 600000;
	localparam int PHASE_ITEMS  = 80;
	localparam int SPECIAL_WORD = 2;
	localparam int HOLD_AT      = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int SHOW_LIMIT   = 50;
	localparam int DIR_ROWS     = 29;

	typedef struct packed {
		status_t                  status;
		logic [HASH_BITS-1:0]     bucket;
		logic [SPREAD_BITS-1:0]   spread;
	} hist_result_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef enum bit {EXP_PRED, EXP_FIXED} exp_src_t;

	typedef struct {
		row_kind_t            kind;
		mode_t                mode;
		op_t                  op;
		logic [CHAR_BITS-1:0] ch;
		int                   reps;
		exp_src_t             src;
		hist_result_t         res;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] char_code
	logic [1:0]  s_axis_tuser = '0;    // [1:0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;         // [15:0] bucket, [39:16] spread
	logic [1:0]  m_axis_tuser;         // [1:0] status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = '0;        // [1:0] hash_mode

	// Predictor state
	bit [CNT_BITS-1:0]  hist_counts [TBL_ENTRIES];
	bit [CHAR_BITS-1:0] word_buf [WORD_MAX];
	int unsigned        word_len = 0;
	bit [HASH_BITS-1:0] word_sum = '0;
	bit                 word_overflow = 1'b0;
	mode_t              hash_sel = MODE_LEN;

	hist_result_t pending_results [$];
	hist_result_t none_res = '0;
	int unsigned  items_sent = 0;
	int unsigned  mismatch_count = 0;
	bit           no_idle = 1'b0;

	// Directed rows; fixed results are the ones obvious from the spec
	step_t directed_steps [DIR_ROWS] = '{
		// empty table, then an empty word
		'{ROW_ITEM, MODE_LEN, OP_REPORT, 8'h00, 1, EXP_FIXED, '{ST_SPREAD, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_LEN, OP_END, 8'h00, 1, EXP_FIXED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_LEN, OP_CHAR, 8'h41, 3, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_LEN, OP_END, 8'h00, 1, EXP_FIXED, '{ST_COUNTED, 16'd3, 24'd0}},
		// longest word that still fits
		'{ROW_ITEM, MODE_LEN, OP_CHAR, 8'hFF, 256, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_LEN, OP_END, 8'h00, 1, EXP_FIXED, '{ST_COUNTED, 16'd256, 24'd0}},
		// one character too many
		'{ROW_ITEM, MODE_LEN, OP_CHAR, 8'h00, 257, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_LEN, OP_END, 8'h00, 1, EXP_FIXED, '{ST_TOO_LONG, 16'd0, 24'd0}},
		// clear in the middle of a word keeps the word
		'{ROW_ITEM, MODE_LEN, OP_CHAR, 8'h80, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_LEN, OP_CLEAR, 8'h00, 1, EXP_FIXED, '{ST_CLEARED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_LEN, OP_CHAR, 8'h7F, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_LEN, OP_END, 8'h00, 1, EXP_FIXED, '{ST_COUNTED, 16'd2, 24'd0}},
		// first character
		'{ROW_CFG, MODE_FIRST, OP_CHAR, 8'h00, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_FIRST, OP_END, 8'h00, 1, EXP_FIXED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_FIRST, OP_CHAR, 8'hFF, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_FIRST, OP_CHAR, 8'h00, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_FIRST, OP_END, 8'h00, 1, EXP_FIXED, '{ST_COUNTED, 16'hFF, 24'd0}},
		// byte sum of the largest word
		'{ROW_CFG, MODE_SUM, OP_CHAR, 8'h00, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_SUM, OP_CHAR, 8'hFF, 256, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_SUM, OP_END, 8'h00, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		// sum plus middle square, wrapping
		'{ROW_CFG, MODE_SUM_SQ, OP_CHAR, 8'h00, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_SUM_SQ, OP_END, 8'h00, 1, EXP_FIXED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_SUM_SQ, OP_CHAR, 8'hFF, 256, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_SUM_SQ, OP_END, 8'h00, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		// report in the middle of a word keeps the word
		'{ROW_ITEM, MODE_SUM_SQ, OP_CHAR, 8'h03, 2, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_SUM_SQ, OP_REPORT, 8'h00, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}},
		'{ROW_ITEM, MODE_SUM_SQ, OP_END, 8'h00, 1, EXP_FIXED, '{ST_COUNTED, 16'd15, 24'd0}},
		'{ROW_ITEM, MODE_SUM_SQ, OP_CLEAR, 8'h00, 1, EXP_FIXED, '{ST_CLEARED, 16'd0, 24'd0}},
		'{ROW_CFG, MODE_LEN, OP_CHAR, 8'h00, 1, EXP_PRED, '{ST_COUNTED, 16'd0, 24'd0}}
	};

	string_hash_bucket_histogram i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bucket histogram predictor: updates state, returns 1 when a result follows
	function automatic bit histogram_step(input op_t op, input logic [CHAR_BITS-1:0] ch,
			output hist_result_t res);
		int unsigned acc;
		int unsigned mid;
		int unsigned b;
		int unsigned top;
		int unsigned low;
		bit          seen;
		bit          produces;
		res = '{ST_COUNTED, '0, '0};
		produces = 1'b1;
		case (op)
			OP_CHAR: begin
				produces = 1'b0;
				if (word_len >= WORD_MAX) begin
					word_overflow = 1'b1;
				end else begin
					word_buf[word_len] = ch;
					word_len++;
					word_sum += ch;
				end
			end
			OP_END: begin
				if (word_overflow) begin
					res.status = ST_TOO_LONG;
				end else begin
					case (hash_sel)
						MODE_LEN:   acc = word_len;
						MODE_FIRST: acc = (word_len > 0) ? word_buf[0] : 0;
						MODE_SUM:   acc = word_sum;
						default: begin
							mid = (word_len / 2 < word_len) ? word_buf[word_len / 2] : 0;
							acc = word_sum + mid * mid;
						end
					endcase
					b = (acc & 32'hFFFF) % TBL_ENTRIES;
					// counters saturate
					if (hist_counts[b] != {CNT_BITS{1'b1}})
						hist_counts[b]++;
					res.bucket = b[HASH_BITS-1:0];
				end
				word_len = 0;
				word_sum = '0;
				word_overflow = 1'b0;
			end
			OP_REPORT: begin
				top = 0;
				low = 0;
				seen = 1'b0;
				for (int i = 0; i < TBL_ENTRIES; i++) begin
					if (hist_counts[i] > top)
						top = hist_counts[i];
					if (hist_counts[i] != 0 && (!seen || hist_counts[i] < low)) begin
						low = hist_counts[i];
						seen = 1'b1;
					end
				end
				res.status = ST_SPREAD;
				res.spread = SPREAD_BITS'(top - low);
			end
			default: begin
				for (int i = 0; i < TBL_ENTRIES; i++)
					hist_counts[i] = '0;
				res.status = ST_CLEARED;
			end
		endcase
		return produces;
	endfunction

	// Offer one item, with random gaps, and predict it on transfer
	task automatic send_item(input op_t op, input logic [CHAR_BITS-1:0] ch,
			input bit fixed, input hist_result_t fixed_res);
		hist_result_t res;
		while (!no_idle && $urandom_range(99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (histogram_step(op, ch, res))
			pending_results.push_back(fixed ? fixed_res : res);
	endtask

	// Hash mode write, only once the block has gone quiet
	task automatic write_mode(input mode_t m);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		hash_sel = m;
	endtask

	// One word of random characters; a special op may be slipped in halfway
	task automatic send_word(input int len, input bit with_special, input op_t special_op);
		for (int i = 0; i < len; i++) begin
			if (with_special && i == len / 2)
				send_item(special_op, CHAR_BITS'($urandom_range(255)), 1'b0, none_res);
			send_item(OP_CHAR, CHAR_BITS'($urandom_range(255)), 1'b0, none_res);
		end
		send_item(OP_END, CHAR_BITS'($urandom_range(255)), 1'b0, none_res);
	endtask

	// Stimulus
	initial begin
		int          r;
		int          len;
		int unsigned phase_start;
		int          words;
		bit          has_special;
		op_t         special_op;
		mode_t       phase_modes [5];
		phase_modes = '{MODE_SUM_SQ, MODE_LEN, MODE_FIRST, MODE_SUM, MODE_LEN};
		phase_modes[4] = mode_t'($urandom_range(3));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		write_mode(MODE_LEN);

		// directed table
		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == ROW_CFG) begin
				write_mode(directed_steps[i].mode);
			end else begin
				for (int k = 0; k < directed_steps[i].reps; k++)
					send_item(directed_steps[i].op, directed_steps[i].ch,
						directed_steps[i].src == EXP_FIXED, directed_steps[i].res);
			end
		end

		// random phases, one hash mode each
		for (int p = 0; p < 5; p++) begin
			write_mode(phase_modes[p]);
			no_idle = (p == 3);
			has_special = (p == 1 || p == 2);
			special_op = (p == 1) ? OP_REPORT : OP_CLEAR;
			phase_start = items_sent;
			words = 0;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(999);
				if (r < 40)
					len = 0;
				else if (r < 920)
					len = $urandom_range(12, 1);
				else if (r < 990)
					len = $urandom_range(40, 13);
				else if (r < 995)
					len = $urandom_range(WORD_MAX, WORD_MAX - 6);
				else
					len = $urandom_range(WORD_MAX + 8, WORD_MAX + 1);
				if (has_special && words == SPECIAL_WORD)
					send_word(6, 1'b1, special_op);
				else
					send_word(len, 1'b0, special_op);
				words++;
			end
		end
		no_idle = 1'b0;
		send_item(OP_REPORT, CHAR_BITS'($urandom_range(255)), 1'b0, none_res);

		// drain
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off, field checks
	initial begin
		int unsigned  results_seen;
		int unsigned  hold_left;
		hist_result_t want;
		results_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count < SHOW_LIMIT)
						$display("%0t: unexpected result, status %0d bucket %0d spread %0d",
							$time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[39:16]);
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tuser !== want.status) begin
						mismatch_count++;
						if (mismatch_count < SHOW_LIMIT)
							$display("%0t: status mismatch, expected %0d, actual %0d",
								$time, want.status, m_axis_tuser);
					end
					if (m_axis_tdata[15:0] !== want.bucket) begin
						mismatch_count++;
						if (mismatch_count < SHOW_LIMIT)
							$display("%0t: bucket mismatch, expected %0d, actual %0d",
								$time, want.bucket, m_axis_tdata[15:0]);
					end
					if (m_axis_tdata[39:16] !== want.spread) begin
						mismatch_count++;
						if (mismatch_count < SHOW_LIMIT)
							$display("%0t: spread mismatch, expected %0d, actual %0d",
								$time, want.spread, m_axis_tdata[39:16]);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(99) >= 33);
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		int unsigned quiet_cycles;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
